[rtl/tvtc_pkg.sv]
// Package for the triangle vertex transform and cull block.
// Holds fixed-point widths, the sequencer state type and saturation helpers.
// Depends on nothing.
`default_nettype none
package tvtc_pkg;

  localparam int FracBits = 16;
  localparam int TermW    = 64 - FracBits;
  localparam int AccW     = TermW + 2;
  localparam int NumW     = 32 + FracBits;
  localparam int BitW     = $clog2(NumW);
  localparam int ProdW    = 66;
  localparam int CfgIdxW  = 2;

  localparam logic       OpCoef     = 1'b0;
  localparam logic       OpVertex   = 1'b1;
  localparam logic [1:0] SlotLast   = 2'd2;
  localparam logic [1:0] SlotIgnore = 2'd3;

  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegNear   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFar    = 2'd3;

  typedef enum logic [3:0] {
    StIdle, StMul, StAdd, StDivLoad, StDivStep, StDivEnd,
    StVpxMul, StVpxCvt, StVpyMul, StVpyCvt, StFinish
  } tvtc_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32'sh7fffffff);
    lo = -AccW'(64'sh80000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [15:0] to_screen(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] adj;
    logic signed [ProdW-1:0] q;
    adj = p;
    if (p[ProdW-1]) adj = p + ProdW'((66'sd1 <<< (FracBits + 1)) - 66'sd1);
    q = adj >>> (FracBits + 1);
    if (q > 66'sd32767) return 16'sh7fff;
    else if (q < -66'sd32768) return 16'sh8000;
    else return q[15:0];
  endfunction

endpackage
`default_nettype wire

[rtl/tvtc_if.sv]
// Channel interfaces of the triangle vertex transform and cull block.
// Input request, result request and register write channels; no dependencies.
`default_nettype none
interface tvtc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic signed [31:0] vert_z;
  logic signed [31:0] vert_w;
  logic [1:0]         vertex_slot;
  modport source (output valid, operation, coef_index, coef_value, vert_x, vert_y,
                  vert_z, vert_w, vertex_slot, input ready);
  modport sink (input valid, operation, coef_index, coef_value, vert_x, vert_y,
                vert_z, vert_w, vertex_slot, output ready);
endinterface

interface tvtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x0;
  logic signed [15:0] screen_y0;
  logic signed [15:0] screen_x1;
  logic signed [15:0] screen_y1;
  logic signed [15:0] screen_x2;
  logic signed [15:0] screen_y2;
  logic               in_frustum;
  modport source (output valid, screen_x0, screen_y0, screen_x1, screen_y1, screen_x2,
                  screen_y2, in_frustum, input ready);
  modport sink (input valid, screen_x0, screen_y0, screen_x1, screen_y1, screen_x2,
                screen_y2, in_frustum, output ready);
endinterface

interface tvtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/triangle_vertex_transform_cull.sv]
// Operation: a coefficient request is written into the matrix when accepted. A vertex
// runs 16 multiply-accumulate pairs on the shared multiplier, then, unless the
// transformed w is zero, three 48-step bit-serial divides by |w|, then two viewport
// multiplies; slot 2 adds a finish state to load the result register, which holds
// while the previous result is not yet taken. One vertex at a time; the input is not
// ready until its vertex finishes.
// Reset clears the matrix to zero, loads the default registers and empties the output.
`default_nettype none
module triangle_vertex_transform_cull
  import tvtc_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  tvtc_in_if.sink    in_i,
  tvtc_out_if.source out_o,
  tvtc_cfg_if.sink   cfg_i
);

  tvtc_state_e state_q, state_d;

  logic signed [31:0] mat_q [16];
  logic signed [31:0] v_q [4];
  logic signed [31:0] t_q [4];
  logic signed [31:0] held_z_q [2];
  logic signed [15:0] held_xy_q [4];
  logic [1:0]         slot_q;
  logic [3:0]         mac_cnt_q;
  logic [1:0]         comp_q;
  logic [BitW-1:0]    bit_q;
  logic [NumW-1:0]    num_q;
  logic [31:0]        rem_q;
  logic [31:0]        den_q;
  logic               neg_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [15:0] sx_q, sy_q;
  logic [12:0]        width_q, height_q;
  logic signed [31:0] near_q, far_q;

  logic               out_valid_q;
  logic signed [15:0] o_x0_q, o_y0_q, o_x1_q, o_y1_q, o_x2_q, o_y2_q;
  logic               o_inf_q;

  logic signed [32:0] mul_a, mul_b;
  logic               in_ready;
  logic               in_acc, out_free, vert_go;
  logic [1:0]         mr, mc;
  logic signed [AccW-1:0] sum;
  logic [32:0]        rem_sh;
  logic               ge;
  logic signed [32:0] t_ext, w_ext, t_mag, w_mag;
  logic [31:0]        q_lo;
  logic               q_big;
  logic signed [31:0] q_res;
  logic               all_in;

  assign mr = mac_cnt_q[3:2];
  assign mc = mac_cnt_q[1:0];
  assign in_acc = in_i.valid && in_ready;
  assign vert_go = in_acc && (in_i.operation == OpVertex) && (in_i.vertex_slot != SlotIgnore);
  assign out_free = !out_valid_q || out_o.ready;

  assign sum = acc_q + AccW'($signed(prod_q[63:FracBits]));
  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign ge = rem_sh >= {1'b0, den_q};
  assign t_ext = {t_q[comp_q][31], t_q[comp_q]};
  assign w_ext = {t_q[3][31], t_q[3]};
  assign t_mag = t_ext[32] ? -t_ext : t_ext;
  assign w_mag = w_ext[32] ? -w_ext : w_ext;
  assign q_big = |num_q[NumW-1:32];
  assign q_lo = num_q[31:0];

  always_comb begin
    if (neg_q) begin
      if (q_big || (q_lo > 32'h80000000)) q_res = 32'sh80000000;
      else q_res = -$signed(q_lo);
    end else begin
      if (q_big || q_lo[31]) q_res = 32'sh7fffffff;
      else q_res = $signed(q_lo);
    end
  end

  assign all_in = (held_z_q[0] > near_q) && (held_z_q[0] < far_q) &&
                  (held_z_q[1] > near_q) && (held_z_q[1] < far_q) &&
                  (t_q[2] > near_q) && (t_q[2] < far_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (vert_go) state_d = StMul;
      StMul:     state_d = StAdd;
      StAdd:     if (mac_cnt_q == 4'd15) state_d = StDivLoad;
                 else state_d = StMul;
      StDivLoad: if (t_q[3] == 32'sd0) state_d = StVpxMul;
                 else state_d = StDivStep;
      StDivStep: if (bit_q == BitW'(NumW - 1)) state_d = StDivEnd;
      StDivEnd:  if (comp_q == 2'd2) state_d = StVpxMul;
                 else state_d = StDivLoad;
      StVpxMul:  state_d = StVpxCvt;
      StVpxCvt:  state_d = StVpyMul;
      StVpyMul:  state_d = StVpyCvt;
      StVpyCvt:  if (slot_q == SlotLast) state_d = StFinish;
                 else state_d = StIdle;
      StFinish:  if (out_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_a = {v_q[mc][31], v_q[mc]};
    mul_b = {mat_q[{mc, mr}][31], mat_q[{mc, mr}]};
    case (state_q)
      StIdle: in_ready = 1'b1;
      StVpxMul: begin
        mul_a = {t_q[0][31], t_q[0]} + 33'(1 << FracBits);
        mul_b = {20'd0, width_q};
      end
      StVpyMul: begin
        mul_a = {t_q[1][31], t_q[1]} + 33'(1 << FracBits);
        mul_b = {20'd0, height_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mac_cnt_q   <= '0;
      comp_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      width_q     <= 13'd640;
      height_q    <= 13'd480;
      near_q      <= 32'sd6554;
      far_q       <= 32'sd6553600;
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_i.operation == OpCoef) mat_q[in_i.coef_index] <= in_i.coef_value;
      if (vert_go) begin
        mac_cnt_q <= '0;
        comp_q    <= '0;
      end
      if (state_q == StAdd) mac_cnt_q <= mac_cnt_q + 4'd1;
      if (state_q == StDivLoad) bit_q <= '0;
      if (state_q == StDivStep) bit_q <= bit_q + BitW'(1);
      if (state_q == StDivEnd) comp_q <= comp_q + 2'd1;
      if (state_q == StFinish && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          RegWidth:  width_q  <= cfg_i.data[12:0];
          RegHeight: height_q <= cfg_i.data[12:0];
          RegNear:   near_q   <= cfg_i.data;
          RegFar:    far_q    <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (vert_go) begin
      v_q[0] <= in_i.vert_x;
      v_q[1] <= in_i.vert_y;
      v_q[2] <= in_i.vert_z;
      v_q[3] <= in_i.vert_w;
      slot_q <= in_i.vertex_slot;
      acc_q  <= '0;
    end
    case (state_q)
      StAdd: begin
        if (mc == 2'd3) begin
          t_q[mr] <= sat32(sum);
          acc_q   <= '0;
        end else begin
          acc_q <= sum;
        end
      end
      StDivLoad: begin
        num_q <= {t_mag[31:0], {FracBits{1'b0}}};
        neg_q <= t_ext[32];
        den_q <= w_mag[31:0];
        rem_q <= '0;
      end
      StDivStep: begin
        rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
        num_q <= {num_q[NumW-2:0], ge};
      end
      StDivEnd: t_q[comp_q] <= q_res;
      StVpxCvt: sx_q <= to_screen(prod_q);
      StVpyCvt: begin
        if (slot_q == SlotLast) begin
          sy_q <= to_screen(prod_q);
        end else begin
          held_xy_q[{slot_q[0], 1'b0}] <= sx_q;
          held_xy_q[{slot_q[0], 1'b1}] <= to_screen(prod_q);
          held_z_q[slot_q[0]] <= t_q[2];
        end
      end
      StFinish: if (out_free) begin
        o_x0_q  <= held_xy_q[0];
        o_y0_q  <= held_xy_q[1];
        o_x1_q  <= held_xy_q[2];
        o_y1_q  <= held_xy_q[3];
        o_x2_q  <= sx_q;
        o_y2_q  <= sy_q;
        o_inf_q <= all_in;
      end
      default: ;
    endcase
  end

  assign in_i.ready       = in_ready;
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.screen_x0  = o_x0_q;
  assign out_o.screen_y0  = o_y0_q;
  assign out_o.screen_x1  = o_x1_q;
  assign out_o.screen_y1  = o_y1_q;
  assign out_o.screen_x2  = o_x2_q;
  assign out_o.screen_y2  = o_y2_q;
  assign out_o.in_frustum = o_inf_q;

endmodule
`default_nettype wire

[rtl/tvtc_checker.sv]
// Port-level checks for the triangle vertex transform and cull block.
// Bound to the top level; uses its channel signals and tvtc_pkg only.
`default_nettype none
module tvtc_checker
  import tvtc_pkg::*;
(
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_operation_i,
  input wire [1:0]  in_slot_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [96:0] out_payload_i
);

  a_busy_after_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_operation_i == OpVertex) && (in_slot_i != SlotIgnore)
    |=> !in_ready_i)
    else $error("input ready right after a vertex request");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without vertex work");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("result changed while stalled");

endmodule

bind triangle_vertex_transform_cull tvtc_checker u_tvtc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .in_slot_i      (in_i.vertex_slot),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_payload_i  ({out_o.screen_x0, out_o.screen_y0, out_o.screen_x1, out_o.screen_y1,
                    out_o.screen_x2, out_o.screen_y2, out_o.in_frustum})
);
`default_nettype wire

[tb/triangle_vertex_transform_cull_tb.sv]
// Testbench for the triangle vertex transform and cull block.
// Drives matrix loads, vertices and register writes; predicts screen points and depth flag.
// Depends on tvtc_pkg, the tvtc_in_if, tvtc_out_if and tvtc_cfg_if interfaces and the block.
`timescale 1ns / 1ps
module triangle_vertex_transform_cull_tb;
  import tvtc_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 400;
  localparam longint One = longint'(1) << FracBits;

  typedef struct {
    logic               operation;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic signed [31:0] vert_w;
    logic [1:0]         vertex_slot;
  } vtx_req_t;

  typedef struct {
    logic signed [15:0] sx0;
    logic signed [15:0] sy0;
    logic signed [15:0] sx1;
    logic signed [15:0] sy1;
    logic signed [15:0] sx2;
    logic signed [15:0] sy2;
    logic               in_box;
  } tri_res_t;

  logic clk_i;
  logic rst_ni;
  tvtc_in_if  in_if ();
  tvtc_out_if out_if ();
  tvtc_cfg_if cfg_if ();

  triangle_vertex_transform_cull dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  longint   xform[16];
  longint   held_xy[4];
  longint   held_z[2];
  longint   width_px;
  longint   height_px;
  longint   near_z;
  longint   far_z;
  bit       slot_seen[2];
  tri_res_t tri_queue[$];
  int       fails;
  int       sent;
  int       send_idle_pct;
  int       stall_pct;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    fails++;
  endtask

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint screen_map(input longint v, input longint size);
    longint t;
    t = (v + One) * size;
    t = t / (One * 2);
    return clamp(t, -32768, 32767);
  endfunction

  function automatic void apply_config(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      RegWidth:  width_px = longint'(data & 32'h1fff);
      RegHeight: height_px = longint'(data & 32'h1fff);
      RegNear:   near_z = longint'(signed'(data));
      RegFar:    far_z = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  function automatic void predict_triangle(input vtx_req_t req);
    longint vin[4];
    longint t[4];
    longint acc;
    longint aw;
    longint sx;
    longint sy;
    longint z[3];
    tri_res_t res;
    bit all_in;
    if (req.operation == OpCoef) begin
      xform[req.coef_index] = longint'(req.coef_value);
      return;
    end
    if (req.vertex_slot == SlotIgnore) return;
    vin[0] = req.vert_x;
    vin[1] = req.vert_y;
    vin[2] = req.vert_z;
    vin[3] = req.vert_w;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += (xform[c * 4 + r] * vin[c]) >>> FracBits;
      t[r] = clamp(acc, -64'sd2147483648, 64'sd2147483647);
    end
    if (t[3] != 0) begin
      aw = t[3] < 0 ? -t[3] : t[3];
      for (int r = 0; r < 3; r++)
        t[r] = clamp((t[r] * One) / aw, -64'sd2147483648, 64'sd2147483647);
    end
    sx = screen_map(t[0], width_px);
    sy = screen_map(t[1], height_px);
    if (req.vertex_slot != SlotLast) begin
      held_xy[req.vertex_slot * 2] = sx;
      held_xy[req.vertex_slot * 2 + 1] = sy;
      held_z[req.vertex_slot] = t[2];
      slot_seen[req.vertex_slot] = 1'b1;
      return;
    end
    z[0] = held_z[0];
    z[1] = held_z[1];
    z[2] = t[2];
    all_in = 1'b1;
    for (int r = 0; r < 3; r++) if (!(z[r] > near_z && z[r] < far_z)) all_in = 1'b0;
    res.sx0 = held_xy[0][15:0];
    res.sy0 = held_xy[1][15:0];
    res.sx1 = held_xy[2][15:0];
    res.sy1 = held_xy[3][15:0];
    res.sx2 = sx[15:0];
    res.sy2 = sy[15:0];
    res.in_box = all_in;
    tri_queue.push_back(res);
  endfunction

  always @(posedge clk_i) begin
    tri_res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (tri_queue.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_res = tri_queue.pop_front();
        if (out_if.screen_x0 !== exp_res.sx0)
          report($sformatf("screen_x0 %0d exp %0d", out_if.screen_x0, exp_res.sx0));
        if (out_if.screen_y0 !== exp_res.sy0)
          report($sformatf("screen_y0 %0d exp %0d", out_if.screen_y0, exp_res.sy0));
        if (out_if.screen_x1 !== exp_res.sx1)
          report($sformatf("screen_x1 %0d exp %0d", out_if.screen_x1, exp_res.sx1));
        if (out_if.screen_y1 !== exp_res.sy1)
          report($sformatf("screen_y1 %0d exp %0d", out_if.screen_y1, exp_res.sy1));
        if (out_if.screen_x2 !== exp_res.sx2)
          report($sformatf("screen_x2 %0d exp %0d", out_if.screen_x2, exp_res.sx2));
        if (out_if.screen_y2 !== exp_res.sy2)
          report($sformatf("screen_y2 %0d exp %0d", out_if.screen_y2, exp_res.sy2));
        if (out_if.in_frustum !== exp_res.in_box)
          report($sformatf("in_frustum %0b exp %0b", out_if.in_frustum, exp_res.in_box));
      end
    end
  end

  task automatic send_request(input vtx_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= req.operation;
    in_if.coef_index  <= req.coef_index;
    in_if.coef_value  <= req.coef_value;
    in_if.vert_x      <= req.vert_x;
    in_if.vert_y      <= req.vert_y;
    in_if.vert_z      <= req.vert_z;
    in_if.vert_w      <= req.vert_w;
    in_if.vertex_slot <= req.vertex_slot;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_triangle(req);
    sent++;
  endtask

  task automatic drain_idle();
    in_if.valid <= 1'b0;
    while (tri_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    drain_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    apply_config(idx, data);
  endtask

  function automatic logic signed [31:0] small_q();
    return signed'($urandom_range(0, 32'h80000)) - 32'sh40000;
  endfunction

  function automatic logic signed [31:0] any_q();
    return $urandom_range(3) == 0 ? signed'($urandom) : small_q();
  endfunction

  task automatic load_coef(input int idx, input logic signed [31:0] value);
    vtx_req_t req;
    req = '{operation: OpCoef, coef_index: idx[3:0], coef_value: value,
            vert_x: $urandom, vert_y: $urandom, vert_z: $urandom, vert_w: $urandom,
            vertex_slot: 2'($urandom)};
    send_request(req);
  endtask

  task automatic send_vertex(input logic [1:0] slot, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z,
                             input logic signed [31:0] w);
    vtx_req_t req;
    req = '{operation: OpVertex, coef_index: 4'($urandom), coef_value: $urandom,
            vert_x: x, vert_y: y, vert_z: z, vert_w: w, vertex_slot: slot};
    send_request(req);
  endtask

  task automatic send_triangle();
    for (int s = 0; s < 3; s++) send_vertex(s[1:0], any_q(), any_q(), any_q(), any_q());
  endtask

  task automatic load_matrix(input int mode);
    for (int i = 0; i < 16; i++) begin
      case (mode)
        0: load_coef(i, (i % 5 == 0) ? 32'sh10000 : 32'sh0);
        1: load_coef(i, (i % 5 == 0 && i != 15) ? 32'sh10000 : (i == 11 ? 32'sh10000 : 0));
        2: load_coef(i, small_q());
        default: load_coef(i, signed'($urandom));
      endcase
    end
  endtask

  task automatic test_directed();
    load_matrix(0);
    send_vertex(2'd0, 32'sh8000, -32'sh8000, 32'sh10000, 32'sh10000);
    send_vertex(2'd1, 32'sh0, 32'sh0, 32'sh20000, 32'sh10000);
    send_vertex(SlotIgnore, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vertex(SlotLast, -32'sh10000, 32'sh10000, 32'sh1999, 32'sh10000);
    send_vertex(2'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh0);
    send_vertex(2'd1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh1);
    send_vertex(SlotLast, 32'sh7fffffff, 32'sh7fffffff, 32'sh0, 32'sh80000000);
  endtask

  task automatic test_config_extremes();
    write_reg(RegWidth, 32'h0);
    write_reg(RegHeight, 32'h1000);
    write_reg(RegNear, 32'h80000000);
    write_reg(RegFar, 32'h7fffffff);
    send_triangle();
    write_reg(RegWidth, 32'hffffffff);
    write_reg(RegHeight, 32'h1);
    write_reg(RegNear, 32'h7fffffff);
    write_reg(RegFar, 32'h80000000);
    send_triangle();
    write_reg(RegWidth, 32'h1000);
    write_reg(RegHeight, 32'h0);
    write_reg(RegNear, 32'h0);
    write_reg(RegFar, 32'h40000);
    load_matrix(1);
    send_triangle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall, input int count);
    int stop_at;
    int pick;
    write_reg(RegWidth, $urandom_range(1) ? $urandom_range(1, 4096) : $urandom);
    write_reg(RegHeight, $urandom_range(1) ? $urandom_range(1, 4096) : $urandom);
    write_reg(RegNear, $urandom_range(1) ? $urandom_range(0, 32'h20000) : $urandom);
    write_reg(RegFar, $urandom_range(1) ? $urandom_range(32'h10000, 32'h800000) : $urandom);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    load_matrix($urandom_range(3));
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_coef($urandom_range(15), any_q());
      end else if (pick < 12) begin
        send_vertex(SlotIgnore, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 18 && slot_seen[0] && slot_seen[1]) begin
        send_vertex($urandom_range(2), any_q(), any_q(), any_q(), any_q());
      end else begin
        send_triangle();
      end
    end
  endtask

  initial begin
    fails = 0;
    sent = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OpCoef;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.vert_x = '0;
    in_if.vert_y = '0;
    in_if.vert_z = '0;
    in_if.vert_w = '0;
    in_if.vertex_slot = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    for (int i = 0; i < 16; i++) xform[i] = 0;
    for (int i = 0; i < 4; i++) held_xy[i] = 0;
    held_z[0] = 0;
    held_z[1] = 0;
    slot_seen[0] = 1'b0;
    slot_seen[1] = 1'b0;
    width_px = 640;
    height_px = 480;
    near_z = (One + 5) / 10;
    far_z = 100 * One;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_phase(0, 0, 150);
    test_random_phase(63, 0, 150);
    test_random_phase(0, 63, 150);
    test_random_phase(23, 23, 150);
    drain_idle();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
